// File: design/esclz_pkg.sv
// Shared types and constants for the escape-coded LZ byte decoder.
package esclz_pkg;

    localparam logic [7:0] ESC_BYTE          = 8'hFF;
    localparam logic [2:0] MIN_LEN           = 3'd3;
    localparam int         HISTORY_DEPTH_DEF = 64;
    localparam int         QUEUE_DEPTH       = 4;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_REF,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       last;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_COPY
    } bk_state_t;

endpackage

// File: design/esclz_in_if.sv
// Compressed byte input channel.
interface esclz_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_in_stream;

    modport source (output valid, output in_byte, output last_in_stream, input ready);
    modport sink   (input valid, input in_byte, input last_in_stream, output ready);
endinterface

// File: design/esclz_out_if.sv
// Decompressed byte output channel.
interface esclz_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: design/esclz_front.sv
// Front end: tracks escapes and turns input bytes into decoder commands.
module esclz_front (
    input  logic                clk,
    input  logic                rst_n,
    esclz_in_if.sink            in,
    input  logic                q_full,
    output logic                q_push,
    output esclz_pkg::cmd_t     q_cmd
);

    logic esc_reg;
    logic esc_next;
    logic accept;

    assign in.ready = !q_full;
    assign accept   = in.valid && !q_full;

    always_comb
    begin
        esc_next   = esc_reg;
        q_push     = 1'b0;
        q_cmd.kind = esclz_pkg::CMD_LIT;
        q_cmd.data = in.in_byte;
        q_cmd.last = in.last_in_stream;
        if (accept)
        begin
            if (!esc_reg)
            begin
                if (in.in_byte != esclz_pkg::ESC_BYTE)
                begin
                    q_push = 1'b1;
                end
                else if (in.last_in_stream)
                begin
                    q_push     = 1'b1;
                    q_cmd.kind = esclz_pkg::CMD_CLEAR;
                end
                else
                begin
                    esc_next = 1'b1;
                end
            end
            else
            begin
                esc_next = 1'b0;
                q_push   = 1'b1;
                if (in.in_byte != esclz_pkg::ESC_BYTE)
                begin
                    q_cmd.kind = esclz_pkg::CMD_REF;
                end
            end
            if (in.last_in_stream)
            begin
                esc_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= 1'b0;
        end
        else
        begin
            esc_reg <= esc_next;
        end
    end

endmodule

// File: design/esclz_queue.sv
// Small command queue between front end and back end.
module esclz_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  esclz_pkg::cmd_t     push_cmd,
    input  logic                pop,
    output logic                valid,
    output logic                full,
    output esclz_pkg::cmd_t     head
);

    localparam int QAW = $clog2(esclz_pkg::QUEUE_DEPTH);
    localparam int CW  = $clog2(esclz_pkg::QUEUE_DEPTH + 1);

    esclz_pkg::cmd_t slot_reg [esclz_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]  wr_ptr_reg;
    logic [QAW-1:0]  rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign valid   = (count_reg != '0);
    assign full    = (count_reg == CW'(esclz_pkg::QUEUE_DEPTH));
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(esclz_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(esclz_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/esclz_back.sv
// Back end: executes literal and copy commands against the history memory.
module esclz_back #(
    parameter int HISTORY_DEPTH = esclz_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  esclz_pkg::cmd_t     q_cmd,
    output logic                q_pop,
    esclz_out_if.source         out
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int PW = AW + 1;

    esclz_pkg::bk_state_t state_reg, state_next;
    logic [7:0]           mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] vld_reg;
    logic [AW-1:0]        wp_reg, wp_next;
    logic [AW-1:0]        src_reg, src_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic                 last_reg, last_next;
    logic [7:0]           rd_data_reg;
    logic                 rd_vld_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;

    logic                 out_free;
    logic                 we, re, clr, emit, emit_last;
    logic [7:0]           emit_byte;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        src_inc, src0;
    logic [6:0]           ref_dist;
    logic [PW-1:0]        dist_mod, wp_ext;
    logic [2:0]           len;
    logic                 fwd;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_free  = !out_valid_reg || out.ready;
    assign src_inc   = ptr_inc(src_reg);
    assign ref_dist  = {1'b0, q_cmd.data[7:2]} + 7'd1;
    assign dist_mod  = (PW'(ref_dist) == PW'(HISTORY_DEPTH)) ? '0 : PW'(ref_dist);
    assign wp_ext    = PW'(wp_reg);
    assign src0      = (wp_ext >= dist_mod) ? AW'(wp_ext - dist_mod)
                                            : AW'(wp_ext + PW'(HISTORY_DEPTH) - dist_mod);
    assign len       = {1'b0, q_cmd.data[1:0]} + esclz_pkg::MIN_LEN;
    assign fwd       = we && (wp_reg == raddr);

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        src_next       = src_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        re             = 1'b0;
        raddr          = src_inc;
        clr            = 1'b0;
        emit           = 1'b0;
        emit_byte      = rd_vld_reg ? rd_data_reg : 8'h00;
        emit_last      = 1'b0;
        we             = 1'b0;
        out_valid_next = out_valid_reg && !out.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            esclz_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.kind)
                        esclz_pkg::CMD_LIT:
                        begin
                            if (out_free)
                            begin
                                q_pop     = 1'b1;
                                emit      = 1'b1;
                                emit_byte = q_cmd.data;
                                emit_last = 1'b1;
                                clr       = q_cmd.last;
                            end
                        end
                        esclz_pkg::CMD_REF:
                        begin
                            q_pop      = 1'b1;
                            re         = 1'b1;
                            raddr      = src0;
                            src_next   = src0;
                            cnt_next   = len;
                            last_next  = q_cmd.last;
                            state_next = esclz_pkg::BK_COPY;
                        end
                        esclz_pkg::CMD_CLEAR:
                        begin
                            q_pop = 1'b1;
                            clr   = 1'b1;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            esclz_pkg::BK_COPY:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_last = (cnt_reg == 3'd1);
                    src_next  = src_inc;
                    re        = 1'b1;
                    cnt_next  = cnt_reg - 3'd1;
                    if (cnt_reg == 3'd1)
                    begin
                        state_next = esclz_pkg::BK_IDLE;
                        clr        = last_reg;
                    end
                end
            end
            default:
            begin
                state_next = esclz_pkg::BK_IDLE;
            end
        endcase

        if (emit)
        begin
            we             = 1'b1;
            wp_next        = ptr_inc(wp_reg);
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
        end
        if (clr)
        begin
            wp_next = '0;
        end
    end

    // History memory with write-to-read forwarding for overlapping copies.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wp_reg] <= emit_byte;
        end
        if (re)
        begin
            rd_data_reg <= fwd ? emit_byte : mem[raddr];
        end
        src_reg      <= src_next;
        last_reg     <= last_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= esclz_pkg::BK_IDLE;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (re)
            begin
                rd_vld_reg <= fwd || vld_reg[raddr];
            end
            if (clr)
            begin
                vld_reg <= '0;
            end
            else if (we)
            begin
                vld_reg[wp_reg] <= 1'b1;
            end
        end
    end

    assign out.valid       = out_valid_reg;
    assign out.out_byte    = out_byte_reg;
    assign out.last_of_run = out_last_reg;

endmodule

// File: design/escape_lz_byte_decoder.sv
// Top level of the escape-coded LZ byte decoder.
// Usage:
//   in  : one compressed byte per transaction, last_in_stream marks the final
//         byte of a stream; history and escape state return to start after it.
//   out : one decompressed byte per transaction, last_of_run set on the final
//         byte produced by an input byte.
// Path: a literal goes through the command queue and then the output register;
//   a back-reference reads history in the idle state and then yields one byte
//   per cycle (3 to 6 bytes) while out is not stalled.
// Throughput: the front end accepts one byte per cycle into a four-entry
//   command queue while the queue is not full. The back end pops no new
//   command during a copy and does length + 1 history reads per reference;
//   an escape opener pushes no command unless it ends the stream.
// Reset: queue, escape flag, write pointer and the per-entry history valid
//   bits clear at once; no clearing pass, the block is ready right away.
// Stall: the output register holds while out.ready is low; the back end
//   stops, the queue fills and then in.ready drops.
module escape_lz_byte_decoder #(
    parameter int HISTORY_DEPTH = esclz_pkg::HISTORY_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    esclz_in_if.sink    in,
    esclz_out_if.source out
);

    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    logic            q_full;
    esclz_pkg::cmd_t push_cmd;
    esclz_pkg::cmd_t head_cmd;

    esclz_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in     (in),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (push_cmd)
    );

    esclz_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .valid    (q_valid),
        .full     (q_full),
        .head     (head_cmd)
    );

    esclz_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .out     (out)
    );

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command popped from empty queue");

    a_out_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && !out.ready) |=> (out.valid && $stable(out.out_byte)))
        else $error("output changed while stalled");
`endif

endmodule

// File: test/tb_top.sv
// Self-checking testbench for escape_lz_byte_decoder: byte predictor, stimulus and checks.
`timescale 1ns / 1ps

class lz_expansion_board;
    typedef logic [$clog2(esclz_pkg::HISTORY_DEPTH_DEF)-1:0] hist_ptr_t;
    typedef struct packed {
        logic [7:0] value;
        logic       fin;
    } expected_byte_t;

    logic           esc_open;
    logic [7:0]     hist [esclz_pkg::HISTORY_DEPTH_DEF];
    hist_ptr_t      wr_ptr;
    expected_byte_t expected_bytes [$];

    int errors     = 0;
    int n_literals = 0;
    int n_esc_ff   = 0;
    int n_refs     = 0;
    int n_dropped  = 0;
    int n_streams  = 0;
    int n_checked  = 0;

    function new();
        restart();
    endfunction

    function void restart();
        esc_open = 1'b0;
        foreach (hist[i])
            hist[i] = 8'h00;
        wr_ptr = '0;
    endfunction

    function void emit(logic [7:0] v, logic fin);
        expected_bytes.push_back('{v, fin});
        hist[wr_ptr] = v;
        wr_ptr++;
    endfunction

    // Notes one accepted input transaction and queues the bytes it decodes to.
    function void absorb_code(logic [7:0] code, logic fin);
        hist_ptr_t src;
        int        len;
        if (!esc_open)
        begin
            if (code != esclz_pkg::ESC_BYTE)
            begin
                emit(code, 1'b1);
                n_literals++;
            end
            else
            begin
                esc_open = 1'b1;
            end
        end
        else
        begin
            esc_open = 1'b0;
            if (code == esclz_pkg::ESC_BYTE)
            begin
                emit(esclz_pkg::ESC_BYTE, 1'b1);
                n_esc_ff++;
            end
            else
            begin
                // distance 64 wraps onto the write pointer itself
                src = wr_ptr - hist_ptr_t'(code[7:2]) - hist_ptr_t'(1);
                len = int'(code[1:0]) + int'(esclz_pkg::MIN_LEN);
                for (int i = 0; i < len; i++)
                begin
                    emit(hist[src], i == len - 1);
                    src++;
                end
                n_refs++;
            end
        end
        if (fin)
        begin
            if (esc_open)
                n_dropped++;
            n_streams++;
            restart();
        end
    endfunction

    function void check_byte(logic [7:0] v, logic fin);
        expected_byte_t e;
        if (expected_bytes.size() == 0)
        begin
            $error("unexpected output transaction: out_byte %02h last_of_run %0b", v, fin);
            errors++;
            return;
        end
        e = expected_bytes.pop_front();
        n_checked++;
        if (v !== e.value)
        begin
            $error("out_byte: expected %02h, actual %02h", e.value, v);
            errors++;
        end
        if (fin !== e.fin)
        begin
            $error("last_of_run: expected %0b, actual %0b", e.fin, fin);
            errors++;
        end
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_CODES = 105;
    localparam int TAIL_CYCLES  = 10;

    logic clk;
    logic rst_n;

    esclz_in_if  in_ch ();
    esclz_out_if out_ch ();

    escape_lz_byte_decoder DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch.sink),
        .out   (out_ch.source)
    );

    lz_expansion_board board = new();

    int cycles       = 0;
    int codes_sent   = 0;
    int input_stalls = 0;
    int burst_left   = 0;
    bit gapless      = 1'b0;
    bit hold_req     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycles <= CYCLE_LIMIT)
            @(posedge clk) cycles++;
        $display("** escape_lz_byte_decoder: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid)
        begin
            if (in_ch.ready)
                board.absorb_code(in_ch.in_byte, in_ch.last_in_stream);
            else
                input_stalls++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_byte(out_ch.out_byte, out_ch.last_of_run);
    end

    // receiver: random stalls, ready bursts, and one long hold-off on request
    initial
    begin
        int stall_left;
        int free_left;
        int r;
        stall_left   = 0;
        free_left    = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            r = $urandom_range(0, 99);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (free_left > 0)
            begin
                out_ch.ready <= 1'b1;
                free_left--;
            end
            else if (r < 3)
            begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(10, 30);
            end
            else if (r < 6)
            begin
                out_ch.ready <= 1'b1;
                free_left = $urandom_range(20, 60);
            end
            else
            begin
                out_ch.ready <= (r >= 30);
            end
        end
    end

    function automatic int pick_sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gapless)
            return 0;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if (r < 4)
        begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // called and returns at a falling edge
    task automatic send_code(input logic [7:0] code, input logic fin);
        int gap;
        gap = pick_sender_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.in_byte        <= code;
        in_ch.last_in_stream <= fin;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        codes_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (board.pending() != 0);
    endtask

    task automatic send_escape(input logic [7:0] code, input logic fin);
        send_code(esclz_pkg::ESC_BYTE, 1'b0);
        send_code(code, fin);
    endtask

    // mostly well-formed literals, escaped 0xFF and references, some stray bytes
    task automatic send_random_stream(input int n_codes);
        int         start;
        int         r;
        logic [7:0] code;
        start = codes_sent;
        while (codes_sent - start < n_codes)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                code = 8'($urandom_range(0, 254));
                send_code(code, 1'b0);
            end
            else if (r < 55)
            begin
                send_escape(esclz_pkg::ESC_BYTE, 1'b0);
            end
            else if (r < 92)
            begin
                code = 8'($urandom_range(0, 254));
                send_escape(code, 1'b0);
            end
            else
            begin
                code = 8'($urandom_range(0, 255));
                send_code(code, 1'b0);
            end
        end
        r    = $urandom_range(0, 99);
        code = 8'($urandom_range(0, 255));
        if (r < 20)
            send_escape(code, 1'b1);
        else if (r < 90)
            send_code(code, 1'b1);
    endtask

    initial
    begin
        int random_start;
        bit pressure_done;
        bit pause_done;
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.in_byte        = 8'h00;
        in_ch.last_in_stream = 1'b0;
        pressure_done        = 1'b0;
        pause_done           = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reference before stream start, literal extremes, escaped 0xFF, overlapping copies
        send_escape(8'hFC, 1'b0);
        send_code(8'h00, 1'b0);
        send_code(8'hFE, 1'b0);
        send_code(8'h55, 1'b0);
        send_code(8'hAA, 1'b0);
        send_escape(esclz_pkg::ESC_BYTE, 1'b0);
        send_escape(8'h00, 1'b0);
        send_escape(8'h07, 1'b0);
        send_escape(8'hFE, 1'b0);
        send_code(8'h01, 1'b1);
        // open escape at end of stream is dropped
        send_code(esclz_pkg::ESC_BYTE, 1'b1);
        // history cleared again: reference ends the stream
        send_code(8'h80, 1'b0);
        send_escape(8'h13, 1'b1);
        send_escape(esclz_pkg::ESC_BYTE, 1'b1);
        wait_for_drain();

        random_start = codes_sent;
        while (codes_sent - random_start < RANDOM_CODES)
        begin
            if (!pressure_done && codes_sent - random_start > 30)
            begin
                hold_req = 1'b1;
                gapless  = 1'b1;
                send_random_stream(16);
                gapless       = 1'b0;
                pressure_done = 1'b1;
            end
            else if (!pause_done && codes_sent - random_start > 80)
            begin
                wait_for_drain();
                pause_done = 1'b1;
            end
            else
            begin
                send_random_stream($urandom_range(2, 20));
            end
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb_top: %0d codes in, %0d bytes checked, %0d streams, %0d input stalls",
                 codes_sent, board.n_checked, board.n_streams, input_stalls);
        $display("tb_top: %0d literals, %0d escaped FF, %0d references, %0d dropped escapes",
                 board.n_literals, board.n_esc_ff, board.n_refs, board.n_dropped);
        if (board.errors == 0)
            $display("** escape_lz_byte_decoder: PASSED **");
        else
            $display("** escape_lz_byte_decoder: FAILED **");
        $finish;
    end
endmodule
